/* hdl/pfs_pkg.sv */
// Package with shared types and constants for the prime factor summary block.
`timescale 1ns / 1ps

package pfs_pkg;

    // Default width of the number to factor.
    localparam int NUM_WIDTH_DEF = 31;

    // Width of the distinct prime count field.
    localparam int COUNT_W = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_MUL,
        S_STRIP,
        S_FINISH
    } pfs_state_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } pfs_op_t;

    typedef struct packed {
        logic    start;
        pfs_op_t op;
    } pfs_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pfs_rsp_t;

endpackage

/* hdl/prime_factor_summary_core.sv */
// Top level: trial division sequencer, accumulators and output register.
`timescale 1ns / 1ps
// Trial divisors run up to the square root of the remaining cofactor; each trial, each
// division that strips a factor and each multiplication into the radical is done by the
// one bit-serial divide/multiply unit.
// One item at a time: a new number is accepted only while the sequencer is idle.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties the output.

module prime_factor_summary_core
    import pfs_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF,
    localparam int IN_W  = ((NUM_WIDTH + 7) / 8) * 8,
    localparam int RES_W = 4 * NUM_WIDTH + COUNT_W + 2,
    localparam int OUT_W = ((RES_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // number
    output logic             m_tvalid,
    input  logic             m_tready,
    // largest_prime, smallest_factor, prime_sum, radical, prime_count, is_prime, too_small
    output logic [OUT_W-1:0] m_tdata
);

    localparam int DIV_W = NUM_WIDTH / 2 + 1;
    localparam int SQ_W  = NUM_WIDTH + 1;

    pfs_state_t           state_reg,     state_next;
    logic [NUM_WIDTH-1:0] n_reg,         n_next;
    logic [NUM_WIDTH-1:0] cof_reg,       cof_next;
    logic [DIV_W-1:0]     d_reg,         d_next;
    logic [SQ_W-1:0]      sq_reg,        sq_next;
    logic [NUM_WIDTH-1:0] largest_reg,   largest_next;
    logic [NUM_WIDTH-1:0] smallest_reg,  smallest_next;
    logic [NUM_WIDTH-1:0] sum_reg,       sum_next;
    logic [NUM_WIDTH-1:0] prod_reg,      prod_next;
    logic [COUNT_W-1:0]   count_reg,     count_next;
    logic                 last_reg,      last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     out_data_reg,  out_data_next;

    pfs_req_t             req;
    pfs_rsp_t             rsp;
    logic [NUM_WIDTH-1:0] opa;
    logic [NUM_WIDTH-1:0] opb;
    logic [NUM_WIDTH-1:0] quotient;
    logic [NUM_WIDTH-1:0] result;

    logic [NUM_WIDTH-1:0] d_ext;
    logic [NUM_WIDTH-1:0] note_val;
    logic                 note_en;
    logic                 below_two;
    logic                 prime;
    logic [NUM_WIDTH-1:0] in_num;

    pfs_arith #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .opa      (opa),
        .opb      (opb),
        .rsp      (rsp),
        .quotient (quotient),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        cof_reg      <= cof_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        largest_reg  <= largest_next;
        smallest_reg <= smallest_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign in_num    = s_tdata[NUM_WIDTH-1:0];
    assign d_ext     = {{(NUM_WIDTH - DIV_W){1'b0}}, d_reg};
    assign below_two = (n_reg < NUM_WIDTH'(2));
    assign prime     = !below_two && (smallest_reg == n_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cof_next       = cof_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        largest_next   = largest_reg;
        smallest_next  = smallest_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        req.start      = 1'b0;
        req.op         = OP_DIV;
        opa            = cof_reg;
        opb            = d_ext;
        note_en        = 1'b0;
        note_val       = d_ext;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next        = in_num;
                    cof_next      = in_num;
                    d_next        = DIV_W'(2);
                    sq_next       = SQ_W'(4);
                    largest_next  = '0;
                    smallest_next = '0;
                    sum_next      = '0;
                    prod_next     = NUM_WIDTH'(1);
                    count_next    = '0;
                    state_next    = (in_num < NUM_WIDTH'(2)) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sq_reg <= {1'b0, cof_reg})
                begin
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    state_next = S_TEST;
                end
                else if (cof_reg > NUM_WIDTH'(1))
                begin
                    // The cofactor left over is the largest prime factor.
                    note_en    = 1'b1;
                    note_val   = cof_reg;
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    opa        = prod_reg;
                    opb        = cof_reg;
                    last_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_TEST:
            begin
                if (rsp.done)
                begin
                    if (result == '0)
                    begin
                        note_en    = 1'b1;
                        cof_next   = quotient;
                        req.start  = 1'b1;
                        req.op     = OP_MUL;
                        opa        = prod_reg;
                        opb        = d_ext;
                        last_next  = 1'b0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + {{(SQ_W - DIV_W - 1){1'b0}}, d_reg, 1'b1};
                        state_next = S_CHECK;
                    end
                end
            end
            S_MUL:
            begin
                if (rsp.done)
                begin
                    prod_next = result;
                    if (last_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.op     = OP_DIV;
                        state_next = S_STRIP;
                    end
                end
            end
            S_STRIP:
            begin
                // Divide the current prime out until it no longer divides.
                if (rsp.done)
                begin
                    if (result == '0)
                    begin
                        cof_next  = quotient;
                        req.start = 1'b1;
                        req.op    = OP_DIV;
                        opa       = quotient;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + {{(SQ_W - DIV_W - 1){1'b0}}, d_reg, 1'b1};
                        state_next = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {!prime && below_two, prime, count_reg, prod_reg, sum_reg,
                                      smallest_reg, largest_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (note_en)
        begin
            if (count_reg == '0)
            begin
                smallest_next = note_val;
            end
            largest_next = note_val;
            sum_next     = sum_reg + note_val;
            count_next   = count_reg + 1'b1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, out_data_reg};

endmodule

/* hdl/pfs_arith.sv */
// Shared bit-serial unit for division with remainder and truncated multiplication.
`timescale 1ns / 1ps

module pfs_arith
    import pfs_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfs_req_t             req,
    input  logic [NUM_WIDTH-1:0] opa,
    input  logic [NUM_WIDTH-1:0] opb,
    output pfs_rsp_t             rsp,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [NUM_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(NUM_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

    pfs_op_t              op_reg,   op_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic [NUM_WIDTH-1:0] a_reg,    a_next;
    logic [NUM_WIDTH-1:0] b_reg,    b_next;
    logic [NUM_WIDTH-1:0] r_reg,    r_next;

    logic [NUM_WIDTH:0]   trial;
    logic                 fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
    end

    // One restoring division step: shift in the next dividend bit and try the divisor.
    assign trial = {r_reg, a_reg[NUM_WIDTH-1]};
    assign fits  = (trial >= {1'b0, b_reg});

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            a_next    = opa;
            b_next    = opb;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_DIV:
                begin
                    a_next = {a_reg[NUM_WIDTH-2:0], fits};
                    r_next = fits ? NUM_WIDTH'(trial - {1'b0, b_reg})
                                  : trial[NUM_WIDTH-1:0];
                end
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        r_next = r_reg + a_reg;
                    end
                    a_next = {a_reg[NUM_WIDTH-2:0], 1'b0};
                    b_next = {1'b0, b_reg[NUM_WIDTH-1:1]};
                end
                default:
                begin
                    r_next = r_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = a_reg;
    assign result   = r_reg;

endmodule
